// ===== hw/rtl/svsd_pkg.sv =====
// Shared types, constants and segment table for the sensor value display driver.
package svsd_pkg;

    localparam int VALUE_W     = 27;              // width of the selected value
    localparam int BCD_DIGITS  = 9;               // decimal digits a 27-bit value can need
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int SEG_W       = 8;
    localparam int OUT_POS     = 8;               // display positions on the output
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 96;
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 31;
    // ceil(2^31 / 10): exact quotient for every 27-bit dividend
    localparam logic [RECIP_W-1:0] RECIP_DIV10 = 28'd214748365;
    localparam int SHIFT_STEPS = VALUE_W;         // double-dabble shift steps

    // Conversion state carried down the pipeline
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
        logic [VALUE_W-1:0] value;
    } svsd_conv_t;

    // Active-high segment pattern of one decimal digit
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'd252;
            4'd1:    pat = 8'd96;
            4'd2:    pat = 8'd218;
            4'd3:    pat = 8'd242;
            4'd4:    pat = 8'd102;
            4'd5:    pat = 8'd182;
            4'd6:    pat = 8'd190;
            4'd7:    pat = 8'd224;
            4'd8:    pat = 8'd254;
            4'd9:    pat = 8'd246;
            default: pat = 8'd0;
        endcase
        return pat;
    endfunction

endpackage

// ===== hw/rtl/svsd_select.sv =====
// First stage: mode selection with divide by ten through a reciprocal multiply.
module svsd_select
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [svsd_pkg::VALUE_W-1:0]        voltage_mv,
    input  logic                                show_temperature,
    output logic                                out_valid,
    input  logic                                out_ready,
    output svsd_pkg::svsd_conv_t                out_data
);
    import svsd_pkg::*;

    localparam int PROD_W = VALUE_W + RECIP_W;

    logic [PROD_W-1:0]  product;
    logic [VALUE_W-1:0] value_next;
    logic               valid_reg;
    svsd_conv_t         data_reg;

    // Divide by ten: multiply by the rounded-up reciprocal and drop the fraction
    always_comb
    begin
        product    = PROD_W'(voltage_mv) * PROD_W'(RECIP_DIV10);
        value_next = show_temperature
                   ? VALUE_W'(product[PROD_W-1:RECIP_SHIFT])
                   : voltage_mv;
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the stage when the next one can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the request payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg.bcd   <= '0;
            data_reg.bin   <= value_next;
            data_reg.value <= value_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    logic unused_quot;
    assign unused_quot = ^product[RECIP_SHIFT-1:0];

endmodule

// ===== hw/rtl/svsd_dd_stage.sv =====
// Double-dabble pipeline stage: a fixed number of add-3 and shift steps.
module svsd_dd_stage
#(
    parameter int STEPS = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  svsd_pkg::svsd_conv_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output svsd_pkg::svsd_conv_t out_data
);
    import svsd_pkg::*;

    localparam int SH_W = BCD_W + VALUE_W;

    logic [SH_W-1:0] sh;
    svsd_conv_t      data_next;
    logic            valid_reg;
    svsd_conv_t      data_reg;

    // Correct each digit above four, then shift in the next binary bit
    always_comb
    begin
        sh = {in_data.bcd, in_data.bin};
        for (int s = 0; s < STEPS; s++)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (sh[VALUE_W + 4*d +: 4] >= 4'd5)
                begin
                    sh[VALUE_W + 4*d +: 4] = sh[VALUE_W + 4*d +: 4] + 4'd3;
                end
            end
            sh = {sh[SH_W-2:0], 1'b0};
        end
        data_next.bcd   = sh[SH_W-1:VALUE_W];
        data_next.bin   = sh[VALUE_W-1:0];
        data_next.value = in_data.value;
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the stage when the next one can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the converted payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/svsd_seg_encode.sv =====
// Last stage: leading-zero blanking and segment encoding into the output register.
module svsd_seg_encode
#(
    parameter int NUM_DIGITS = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  svsd_pkg::svsd_conv_t                in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [svsd_pkg::OUT_TDATA_W-1:0]    out_tdata
);
    import svsd_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - OUT_POS*SEG_W - VALUE_W;

    logic [BCD_DIGITS-1:0]       nonzero;
    logic [BCD_DIGITS-1:0]       upper_nz;
    logic [OUT_POS*SEG_W-1:0]    seg_next;
    logic                        valid_reg;
    logic [OUT_POS*SEG_W-1:0]    seg_reg;
    logic [VALUE_W-1:0]          shown_reg;

    // Show a position when it is within the digit count and either it is position zero or the value reaches it
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            nonzero[d] = |in_data.bcd[4*d +: 4];
        end
        upper_nz[BCD_DIGITS-1] = nonzero[BCD_DIGITS-1];
        for (int d = BCD_DIGITS-2; d >= 0; d--)
        begin
            upper_nz[d] = nonzero[d] | upper_nz[d+1];
        end
        for (int k = 0; k < OUT_POS; k++)
        begin
            if ((k == 0 || upper_nz[k]) && k < NUM_DIGITS)
            begin
                seg_next[SEG_W*k +: SEG_W] = seg_pattern(in_data.bcd[4*k +: 4]);
            end
            else
            begin
                seg_next[SEG_W*k +: SEG_W] = '0;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            seg_reg   <= seg_next;
            shown_reg <= in_data.value;
        end
    end

    assign out_valid = valid_reg;
    assign out_tdata = {{PAD_W{1'b0}}, shown_reg, seg_reg};

    logic unused_bin;
    assign unused_bin = ^in_data.bin;

endmodule

// ===== hw/rtl/sensor_value_seven_segment_display.sv =====
// Top level of the sensor value seven-segment display driver.
//
//  Channel  | Direction | tdata (low bit up)                          | tuser
//  s_axis   | in        | voltage_mv[26:0], zero pad to 32 bits       | show_temperature
//  m_axis   | out       | seg_pos0..seg_pos7 (8 each), shown_value,   | -
//           |           | zero pad to 96 bits                         |
//
// One request per cycle while m_axis is not stalled; a result shows on m_axis after
// passing through six register stages (select and divide, four double-dabble
// stages of 7/7/7/6 steps, encode), the first loaded at the accepting edge.
// Each stage has its own valid bit and takes a new request when empty or when
// its successor advances, so bubbles close up while the output stalls.
// rst_n clears only the valid bits; payload registers are not reset.
module sensor_value_seven_segment_display
#(
    parameter int NUM_DIGITS = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [svsd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // voltage_mv[26:0], pad
    input  logic [0:0]                          s_axis_tuser,   // show_temperature
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [svsd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // seg_pos0..7, shown_value, pad
);
    import svsd_pkg::*;

    localparam int NUM_DD  = 4;
    localparam int STEPS_A = 7;
    localparam int STEPS_L = SHIFT_STEPS - (NUM_DD-1)*STEPS_A;

    logic       vld  [NUM_DD+1];
    logic       rdy  [NUM_DD+1];
    svsd_conv_t data [NUM_DD+1];
    logic       enc_ready;

    // Select the shown value
    svsd_select u_select
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .voltage_mv       (s_axis_tdata[VALUE_W-1:0]),
        .show_temperature (s_axis_tuser[0]),
        .out_valid        (vld[0]),
        .out_ready        (rdy[0]),
        .out_data         (data[0])
    );

    // Convert binary to decimal digits
    for (genvar g = 0; g < NUM_DD; g++)
    begin : g_dd
        svsd_dd_stage
        #(
            .STEPS ((g == NUM_DD-1) ? STEPS_L : STEPS_A)
        )
        u_dd
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_data   (data[g]),
            .out_valid (vld[g+1]),
            .out_ready ((g == NUM_DD-1) ? enc_ready : rdy[g+1]),
            .out_data  (data[g+1])
        );
    end

    assign rdy[NUM_DD] = enc_ready;

    // Blank leading positions and encode segments
    svsd_seg_encode
    #(
        .NUM_DIGITS (NUM_DIGITS)
    )
    u_encode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld[NUM_DD]),
        .in_ready  (enc_ready),
        .in_data   (data[NUM_DD]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tdata (m_axis_tdata)
    );

    logic unused_in;
    assign unused_in = ^s_axis_tdata[IN_TDATA_W-1:VALUE_W] ^ rdy[NUM_DD];

endmodule

// ===== hw/rtl/svsd_checker.sv =====
// Port-level checks for the sensor value display driver, bound to the top level.
module svsd_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [svsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import svsd_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // Position zero always shows a digit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[SEG_W-1:0] != '0)
        else $error("least significant position blank");

    // Single-digit values blank position one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_POS*SEG_W +: VALUE_W] < VALUE_W'(10)
        |-> m_axis_tdata[SEG_W +: SEG_W] == '0)
        else $error("leading zero shown for single-digit value");

    // Blank positions stay blank above
    for (genvar k = 1; k < OUT_POS-1; k++)
    begin : g_blank
        assert property (@(posedge clk) disable iff (!rst_n)
            m_axis_tvalid && m_axis_tdata[SEG_W*k +: SEG_W] == '0
            |-> m_axis_tdata[SEG_W*(k+1) +: SEG_W] == '0)
            else $error("digit shown above a blank position");
    end

endmodule

bind sensor_value_seven_segment_display svsd_checker u_svsd_checker (.*);
